// ----- sv/rcm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared types and constants for the trimmed cluster median block.
// ----------------------------------------------------------------------------
package rcm_pkg;

  localparam int VALUE_W = 16;
  localparam int TRIM_W  = 6;

  localparam logic [TRIM_W-1:0] TRIM_RESET = 6'd15;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               is_last;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] cluster_value;
    logic               dropped;
  } result_t;

  typedef struct packed {
    logic [VALUE_W-1:0] x;
    logic [VALUE_W-1:0] y;
  } sub_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] diff;
    logic               gt;
  } sub_rsp_t;

endpackage

// ----- sv/rcm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rcm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/rcm_sub_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_sub_unit
// Shared subtract and compare unit: difference x - y and the flag x > y.
// ----------------------------------------------------------------------------
module rcm_sub_unit (
  input  rcm_pkg::sub_req_t req,
  output rcm_pkg::sub_rsp_t rsp
);

  import rcm_pkg::*;

  logic [VALUE_W:0] wide;

  assign wide     = {1'b0, req.x} - {1'b0, req.y};
  assign rsp.diff = wide[VALUE_W-1:0];
  assign rsp.gt   = !wide[VALUE_W] && (wide[VALUE_W-1:0] != '0);

endmodule

// ----- sv/robust_cluster_median.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// robust_cluster_median
// Collects a set of values into a sorted store, trims outliers from either
// end and reports the median of what remains.
// ----------------------------------------------------------------------------
//  channel   signals                      handshake
//  item      start, busy, item            taken when start && !busy
//  result    result_valid, result         one-cycle strobe, no back-pressure
//  config    cfg_valid, cfg_ready, data   written when valid && ready
//
//  a stored item keeps busy high for a read and compare per value shifted,
//  with no compare when it lands in the bottom slot; an item for a full store
//  is not stored; a last item then runs the trimming rounds and a final read,
//  each round serialised by the single RAM read port and the shared subtractor
//  reset clears the fill count, overflow flag and trim_steps (to 15); the
//  store itself is not cleared; the receiver cannot stall the result
// ----------------------------------------------------------------------------
module robust_cluster_median #(
  parameter int MAX_POINTS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  rcm_pkg::item_t                item,
  output logic                          result_valid,
  output rcm_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rcm_pkg::TRIM_W-1:0]    cfg_data
);

  import rcm_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INS_RD = 4'd1;
  localparam logic [3:0] S_INS_CM = 4'd2;
  localparam logic [3:0] S_T_CHK  = 4'd3;
  localparam logic [3:0] S_T_MID  = 4'd4;
  localparam logic [3:0] S_T_HI   = 4'd5;
  localparam logic [3:0] S_T_CMP  = 4'd6;
  localparam logic [3:0] S_T_DEC  = 4'd7;
  localparam logic [3:0] S_FINAL  = 4'd8;

  logic [3:0]         state;
  logic [CW-1:0]      fill_count;
  logic               overflow_seen;
  logic [TRIM_W-1:0]  trim_steps;
  logic [TRIM_W-1:0]  round;
  logic [VALUE_W-1:0] cur_value;
  logic               cur_last;
  logic [AW-1:0]      pos;
  logic [AW-1:0]      lo;
  logic [AW-1:0]      hi;
  logic [VALUE_W-1:0] lo_val;
  logic [VALUE_W-1:0] mid_val;
  logic [VALUE_W-1:0] below;
  logic [VALUE_W-1:0] above;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;
  logic [AW-1:0]      raddr;
  logic [VALUE_W-1:0] rdata;
  logic [AW:0]        mid_sum;
  logic [AW-1:0]      mid;
  logic [CW-1:0]      fill_dec;
  sub_req_t           sub_req;
  sub_rsp_t           sub_rsp;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid       = mid_sum[AW:1];
  assign fill_dec  = fill_count - CW'(1);

  rcm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  rcm_sub_unit u_sub (
    .req (sub_req),
    .rsp (sub_rsp)
  );

  always_comb begin
    we        = 1'b0;
    waddr     = pos;
    wdata     = cur_value;
    raddr     = lo;
    sub_req.x = rdata;
    sub_req.y = cur_value;
    unique case (state)
      S_INS_RD: begin
        raddr = pos - AW'(1);
        if (pos == '0) begin
          we = 1'b1;
        end
      end
      S_INS_CM: begin
        we = 1'b1;
        if (sub_rsp.gt) begin
          wdata = rdata;
        end
      end
      S_T_CHK: begin
        raddr = lo;
        if (!((round < trim_steps) && (hi > lo))) begin
          raddr = mid;
        end
      end
      S_T_MID: raddr = mid;
      S_T_HI: begin
        raddr     = hi;
        sub_req.y = lo_val;
      end
      S_T_CMP: sub_req.y = mid_val;
      S_T_DEC: begin
        sub_req.x = below;
        sub_req.y = above;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fill_count    <= '0;
      overflow_seen <= 1'b0;
      trim_steps    <= TRIM_RESET;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        trim_steps <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cur_value <= item.value;
            cur_last  <= item.is_last;
            pos       <= fill_count[AW-1:0];
            if (fill_count == CW'(MAX_POINTS)) begin
              overflow_seen <= 1'b1;
              if (item.is_last) begin
                lo    <= '0;
                hi    <= fill_dec[AW-1:0];
                round <= '0;
                state <= S_T_CHK;
              end
            end else begin
              state <= S_INS_RD;
            end
          end
        end
        S_INS_RD: begin
          if (pos == '0) begin
            fill_count <= fill_count + CW'(1);
            lo         <= '0;
            hi         <= fill_count[AW-1:0];
            round      <= '0;
            state      <= cur_last ? S_T_CHK : S_IDLE;
          end else begin
            state <= S_INS_CM;
          end
        end
        S_INS_CM: begin
          if (sub_rsp.gt) begin
            pos   <= pos - AW'(1);
            state <= S_INS_RD;
          end else begin
            fill_count <= fill_count + CW'(1);
            lo         <= '0;
            hi         <= fill_count[AW-1:0];
            round      <= '0;
            state      <= cur_last ? S_T_CHK : S_IDLE;
          end
        end
        S_T_CHK: begin
          if ((round < trim_steps) && (hi > lo)) begin
            state <= S_T_MID;
          end else begin
            state <= S_FINAL;
          end
        end
        S_T_MID: begin
          lo_val <= rdata;
          state  <= S_T_HI;
        end
        S_T_HI: begin
          below   <= sub_rsp.diff;
          mid_val <= rdata;
          state   <= S_T_CMP;
        end
        S_T_CMP: begin
          above <= sub_rsp.diff;
          state <= S_T_DEC;
        end
        S_T_DEC: begin
          if (sub_rsp.gt) begin
            lo <= lo + AW'(1);
          end else begin
            hi <= hi - AW'(1);
          end
          round <= round + TRIM_W'(1);
          state <= S_T_CHK;
        end
        S_FINAL: begin
          result_valid         <= 1'b1;
          result.cluster_value <= rdata;
          result.dropped       <= overflow_seen;
          fill_count           <= '0;
          overflow_seen        <= 1'b0;
          state                <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(MAX_POINTS))
    else $error("fill count beyond store depth");

  a_window_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_T_MID || state == S_T_HI || state == S_T_CMP || state == S_T_DEC)
    |-> (lo < hi))
    else $error("trim window collapsed during a round");

  a_overflow_flag: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && fill_count == CW'(MAX_POINTS)) |=> overflow_seen)
    else $error("overflow not recorded");

  a_result_from_final: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(state) == S_FINAL) && (fill_count == '0))
    else $error("result without final read");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for robust_cluster_median. Sets of values are fed
// through the start/busy port with random gaps. A local sorted-store model
// predicts each trimmed median and its overflow flag. The monitor compares
// every result strobe against the oldest prediction. trim_steps is rewritten
// between phases, covering 0, 1, 7, 63, the reset value and one random setting.
// ----------------------------------------------------------------------------
module tb;

  localparam int STORE_DEPTH = 32;
  localparam int IDLE_LIMIT  = 4000;
  localparam int SETTLE      = 100;
  localparam int PHASE_ITEMS = 175;

  typedef struct {
    rcm_pkg::item_t it;
    int unsigned    gap;
    bit             drain;
  } pend_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  rcm_pkg::item_t             item = '0;
  logic                       result_valid;
  rcm_pkg::result_t           result;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [rcm_pkg::TRIM_W-1:0] cfg_data = '0;

  pend_t            pending[$];
  rcm_pkg::result_t medians_due[$];
  int               due_cnt = 0;
  int               got_cnt = 0;
  int               mismatches = 0;
  int               idle_cycles = 0;

  bit [rcm_pkg::VALUE_W-1:0] model_store [STORE_DEPTH];
  int                        model_fill = 0;
  bit                        model_ovf = 1'b0;
  bit [rcm_pkg::TRIM_W-1:0]  model_trim = rcm_pkg::TRIM_RESET;

  robust_cluster_median #(
    .MAX_POINTS(STORE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .result_valid(result_valid),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sorted insert, then trimmed median on the last value of a set
  function automatic bit absorb_value(input rcm_pkg::item_t it,
                                      output rcm_pkg::result_t med);
    int pos;
    int lo;
    int hi;
    int mid;
    int below;
    int above;
    int k;
    med = '0;
    if (model_fill < STORE_DEPTH) begin
      pos = model_fill;
      while (pos > 0 && model_store[pos-1] > it.value) begin
        model_store[pos] = model_store[pos-1];
        pos--;
      end
      model_store[pos] = it.value;
      model_fill++;
    end else begin
      model_ovf = 1'b1;
    end
    if (!it.is_last) return 1'b0;
    lo = 0;
    hi = model_fill - 1;
    for (k = 0; k < int'(model_trim) && hi > lo; k++) begin
      mid = (lo + hi) >> 1;
      below = int'(model_store[mid]) - int'(model_store[lo]);
      above = int'(model_store[hi]) - int'(model_store[mid]);
      if (below > above) lo++;
      else hi--;
    end
    med.cluster_value = model_store[(lo + hi) >> 1];
    med.dropped = model_ovf;
    model_fill = 0;
    model_ovf = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %h, got %h", what, want, got);
  endtask

  // driver
  always @(posedge clk) begin
    rcm_pkg::result_t med;
    bit taken;
    if (rst) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        if (absorb_value(item, med)) begin
          medians_due.insert(medians_due.size(), med);
          due_cnt <= due_cnt + 1;
        end
      end
      if (!start || taken) begin
        if (pending.size() == 0) begin
          start <= 1'b0;
        end else if (pending[0].gap != 0) begin
          pending[0].gap = pending[0].gap - 1;
          start <= 1'b0;
        end else if (pending[0].drain && (start || due_cnt != got_cnt)) begin
          start <= 1'b0;
        end else begin
          item <= pending[0].it;
          start <= 1'b1;
          void'(pending.pop_front());
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rcm_pkg::result_t want;
    if (!rst && result_valid) begin
      if (got_cnt >= due_cnt) begin
        report_mismatch("unexpected result", 0, int'(result));
      end else begin
        want = medians_due.pop_front();
        if (result.cluster_value !== want.cluster_value)
          report_mismatch("cluster_value", int'(want.cluster_value),
                          int'(result.cluster_value));
        if (result.dropped !== want.dropped)
          report_mismatch("dropped", int'(want.dropped), int'(result.dropped));
        got_cnt <= got_cnt + 1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk); while (pending.size() != 0 || start || due_cnt != got_cnt);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_trim(input logic [rcm_pkg::TRIM_W-1:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_trim = v;
  endtask

  task automatic push_set(input bit [rcm_pkg::VALUE_W-1:0] vals[$], input bit drain);
    pend_t p;
    bit quick;
    quick = ($urandom_range(0, 3) == 0);
    foreach (vals[i]) begin
      p.it.value = vals[i];
      p.it.is_last = (i == vals.size() - 1);
      p.gap = quick ? 0 : $urandom_range(0, 4);
      p.drain = drain && (i == 0);
      pending.insert(pending.size(), p);
    end
  endtask

  function automatic bit [rcm_pkg::VALUE_W-1:0] pick_value(input int style,
                                                           input bit [15:0] base);
    case (style)
      0: return 16'($urandom);
      1: begin
        if ($urandom_range(0, 5) == 0) return 16'($urandom);
        return base + 16'($urandom_range(0, 15));
      end
      2: begin
        case ($urandom_range(0, 2))
          0: return 16'h0000;
          1: return 16'hffff;
          default: return 16'($urandom);
        endcase
      end
      default: return base + 16'($urandom_range(0, 2) * 1000);
    endcase
  endfunction

  function automatic int random_size();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 8);
    if (r < 9) return $urandom_range(9, 32);
    return $urandom_range(33, 40);
  endfunction

  task automatic fill_phase(input int target);
    bit [rcm_pkg::VALUE_W-1:0] vals[$];
    bit [15:0] base;
    int n;
    int style;
    int added;
    added = 0;
    while (added < target) begin
      // first set drains the pipe, second overflows the store
      if (added == 0) n = $urandom_range(3, 8);
      else if (added < 20) n = $urandom_range(33, 40);
      else n = random_size();
      style = $urandom_range(0, 3);
      base = 16'($urandom);
      vals.delete();
      for (int i = 0; i < n; i++) vals.insert(vals.size(), pick_value(style, base));
      push_set(vals, added == 0);
      added += n;
    end
  endtask

  initial begin
    bit [rcm_pkg::VALUE_W-1:0] vals[$];
    logic [rcm_pkg::TRIM_W-1:0] trims[6];
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed sets at the reset trim count
    vals = {16'h0000};
    push_set(vals, 1'b0);
    vals = {16'hffff};
    push_set(vals, 1'b0);
    vals = {16'h0000, 16'hffff};
    push_set(vals, 1'b0);
    vals = {16'hffff, 16'h0000, 16'h8000, 16'h0001, 16'hfffe};
    push_set(vals, 1'b0);
    vals = {16'd7, 16'd7, 16'd7, 16'd7};
    push_set(vals, 1'b0);
    vals = {16'd100, 16'd101, 16'd102, 16'd103, 16'd104, 16'd105, 16'd50000};
    push_set(vals, 1'b0);
    vals = {16'd1, 16'd60000, 16'd60001, 16'd60002, 16'd60003};
    push_set(vals, 1'b0);

    trims[0] = '0;
    trims[1] = '1;
    trims[2] = 6'd1;
    trims[3] = 6'($urandom_range(2, 62));
    trims[4] = 6'd7;
    trims[5] = rcm_pkg::TRIM_RESET;
    foreach (trims[i]) begin
      write_trim(trims[i]);
      @(negedge clk);
      fill_phase(PHASE_ITEMS);
    end

    wait_idle();
    if (mismatches == 0 && medians_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
